@@ hdl/lzss_window256_decoder_assert.svh @@
// Assertion macros for the LZSS 256-byte window decoder.
// Needs nothing else; the including module supplies clock and reset names.
`ifndef LZSS_WINDOW256_DECODER_ASSERT_SVH
`define LZSS_WINDOW256_DECODER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LZSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lzsw assertion failed");

// Check that cons holds in the cycle after ante.
`define LZSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lzsw assertion failed");

`endif

@@ hdl/lzsw_pkg.sv @@
// Shared constants and controller/datapath signal groups for the LZSS decoder.
// No dependencies.
package lzsw_pkg;

	localparam int WINDOW_SIZE = 256;
	localparam int PTR_W       = $clog2(WINDOW_SIZE);
	localparam int OUT_LANES   = 4;
	localparam int LANE_IDX_W  = $clog2(OUT_LANES);
	localparam int CNT_W       = $clog2(OUT_LANES + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_RD     = 5'b00100,
		ST_WR     = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic set_flags;
		logic save_len;
		logic start_copy;
		logic put_lit;
		logic ring_rd;
		logic put_copy;
		logic emit;
		logic finish;
		logic end_stream;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic flag_zero;
		logic flag_lit;
		logic awaiting;
		logic byte_zero;
		logic len_zero;
		logic remain_zero;
		logic last_put;
		logic lane_last;
		logic fill_zero;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/lzsw_in_if.sv @@
// Compressed byte channel: valid/ready handshake with one byte of payload.
// Depends on nothing.
interface lzsw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

@@ hdl/lzsw_out_if.sv @@
// Decoded result channel: up to four bytes per word plus count and markers.
// Depends on nothing.
interface lzsw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic [7:0] out_byte3;
	logic [2:0] byte_count;
	logic       last_of_run;
	logic       stream_end;

	modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
		output out_byte3, output byte_count, output last_of_run, output stream_end,
		input ready);
	modport sink (input valid, input out_byte0, input out_byte1, input out_byte2,
		input out_byte3, input byte_count, input last_of_run, input stream_end,
		output ready);
endinterface

@@ hdl/lzss_window256_decoder.sv @@
// LZSS decoder with a 256-byte history window, top level.
// Depends on lzsw_pkg, lzsw_in_if, lzsw_out_if, lzsw_ctrl, lzsw_dpath and the assert header.
//
// Usage:
//   stream: one compressed byte per word (control, literal, length or offset).
//   result: up to four decoded bytes per word, byte_count valid lanes (unused lanes
//     are zero), last_of_run on the final word caused by an input byte, stream_end
//     on the single word a zero control byte produces.
// Sequence (no output stall):
//   control, length and zero-length copy bytes: capture, then decode; no word.
//   literal: capture, then decode and put, then the word is loaded into the result register.
//   copy of L bytes: capture and decode, then a ring read and a write back for each
//     byte, with a result load after every fourth byte and after the last. The
//     single-port history ring reads a byte in ST_RD and writes it back in ST_WR.
//   stream end: capture and decode, one word, then all state including the ring is clear.
// Reset clears the decode state, the output valid flag and the ring's per-entry
//   valid bits, so the ring reads as zero at once; no clearing pass is needed.
// A stalled receiver holds the result register; the block waits at its next
//   result load and takes no new byte until the current one is fully decoded.
module lzss_window256_decoder (
	input  logic       clk,
	input  logic       arst_n,
	lzsw_in_if.sink    stream,
	lzsw_out_if.source result
);

	lzsw_pkg::cmd_t   cmd;
	lzsw_pkg::sts_t   sts;
	lzsw_pkg::state_t state;

	// sequence the work for each byte
	lzsw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.sts    (sts),
		.cmd    (cmd),
		.state  (state)
	);

	// hold decode state, history ring and the result register
	lzsw_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (stream.in_byte),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

`include "lzss_window256_decoder_assert.svh"

	// a result load never overwrites a word the receiver has not taken
	`LZSW_ASSERT_NOW(a_emit_free, clk, arst_n, cmd.emit || cmd.end_stream, sts.out_free)
	// a ring read only happens while copy bytes remain
	`LZSW_ASSERT_NOW(a_rd_remain, clk, arst_n, cmd.ring_rd, !sts.remain_zero)
	// a new byte is taken only with the lane packer drained
	`LZSW_ASSERT_NOW(a_accept_empty, clk, arst_n,
		stream.valid && stream.ready && state == lzsw_pkg::ST_IDLE, sts.fill_zero)
	// stream end leaves the decoder expecting a control byte
	`LZSW_ASSERT_NEXT(a_end_clear, clk, arst_n, cmd.end_stream,
		sts.flag_zero && !sts.awaiting && sts.len_zero)

endmodule

@@ hdl/lzsw_dpath.sv @@
// Datapath: decode state, history ring with valid bits, lane packer, result register.
// Depends on lzsw_pkg and lzsw_out_if.
module lzsw_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  lzsw_pkg::cmd_t    cmd,
	output lzsw_pkg::sts_t    sts,
	lzsw_out_if.source        result
);

	logic [7:0]                    byte_q;
	logic [7:0]                    flag_q;
	logic                          await_q;
	logic [7:0]                    len_q;
	logic [lzsw_pkg::PTR_W-1:0]    wp_q;
	logic [lzsw_pkg::PTR_W-1:0]    src_q;
	logic [7:0]                    count_q;
	logic [lzsw_pkg::CNT_W-1:0]    fill_q;
	logic [7:0]                    lane_q [lzsw_pkg::OUT_LANES];
	logic [7:0]                    mem [lzsw_pkg::WINDOW_SIZE];
	logic [lzsw_pkg::WINDOW_SIZE-1:0] ring_vld_q;
	logic [7:0]                    rdata_q;
	logic                          rvalid_q;

	logic                          out_valid_q;
	logic [7:0]                    out_lane_q [lzsw_pkg::OUT_LANES];
	logic [lzsw_pkg::CNT_W-1:0]    out_count_q;
	logic                          out_last_q;
	logic                          out_end_q;

	logic                          put;
	logic [7:0]                    put_byte;
	logic [7:0]                    copy_byte;
	logic [7:0]                    flag_shr;
	logic [7:0]                    flag_adv;
	logic                          out_free;

	assign copy_byte = rvalid_q ? rdata_q : 8'h00;
	assign put       = cmd.put_lit | cmd.put_copy;
	assign put_byte  = cmd.put_lit ? byte_q : copy_byte;
	assign flag_shr  = flag_q >> 1;
	assign flag_adv  = (flag_shr <= 8'h01) ? 8'h00 : flag_shr;
	assign out_free  = !out_valid_q || result.ready;

	always_comb begin
		sts.flag_zero   = (flag_q == 8'h00);
		sts.flag_lit    = flag_q[0];
		sts.awaiting    = await_q;
		sts.byte_zero   = (byte_q == 8'h00);
		sts.len_zero    = (len_q == 8'h00);
		sts.remain_zero = (count_q == 8'h00);
		sts.last_put    = (count_q == 8'h01);
		sts.lane_last   = (fill_q == lzsw_pkg::CNT_W'(lzsw_pkg::OUT_LANES - 1));
		sts.fill_zero   = (fill_q == '0);
		sts.out_free    = out_free;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= '0;
			await_q     <= 1'b0;
			len_q       <= '0;
			wp_q        <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			ring_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.set_flags) begin
				flag_q <= (byte_q > 8'h01) ? byte_q : 8'h00;
			end
			if (cmd.save_len) begin
				len_q   <= byte_q;
				await_q <= 1'b1;
			end
			if (cmd.start_copy) begin
				count_q <= len_q;
			end
			if (cmd.put_lit) begin
				count_q <= '0;
			end
			if (cmd.put_copy) begin
				count_q <= count_q - 8'h01;
			end
			if (put) begin
				ring_vld_q[wp_q] <= 1'b1;
				wp_q             <= wp_q + 1'b1;
				fill_q           <= fill_q + 1'b1;
			end
			if (cmd.emit) begin
				fill_q <= '0;
			end
			if (cmd.finish) begin
				flag_q  <= flag_adv;
				await_q <= 1'b0;
				len_q   <= '0;
			end
			if (cmd.end_stream) begin
				flag_q     <= '0;
				await_q    <= 1'b0;
				len_q      <= '0;
				wp_q       <= '0;
				count_q    <= '0;
				fill_q     <= '0;
				ring_vld_q <= '0;
			end
			if (cmd.emit || cmd.end_stream) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and history ring
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= in_byte;
		end
		if (cmd.start_copy) begin
			src_q <= wp_q + byte_q;
		end
		if (cmd.put_copy) begin
			src_q <= src_q + 1'b1;
		end
		if (put) begin
			mem[wp_q]                              <= put_byte;
			lane_q[fill_q[lzsw_pkg::LANE_IDX_W-1:0]] <= put_byte;
		end
		if (cmd.ring_rd) begin
			rdata_q  <= mem[src_q];
			rvalid_q <= ring_vld_q[src_q];
		end
		if (cmd.emit) begin
			for (int i = 0; i < lzsw_pkg::OUT_LANES; i++) begin
				out_lane_q[i] <= (lzsw_pkg::CNT_W'(i) < fill_q) ? lane_q[i] : 8'h00;
			end
			out_count_q <= fill_q;
			out_last_q  <= (count_q == 8'h00);
			out_end_q   <= 1'b0;
		end
		if (cmd.end_stream) begin
			for (int i = 0; i < lzsw_pkg::OUT_LANES; i++) begin
				out_lane_q[i] <= 8'h00;
			end
			out_count_q <= '0;
			out_last_q  <= 1'b1;
			out_end_q   <= 1'b1;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_byte0   = out_lane_q[0];
	assign result.out_byte1   = out_lane_q[1];
	assign result.out_byte2   = out_lane_q[2];
	assign result.out_byte3   = out_lane_q[3];
	assign result.byte_count  = out_count_q;
	assign result.last_of_run = out_last_q;
	assign result.stream_end  = out_end_q;

endmodule

@@ hdl/lzsw_ctrl.sv @@
// Controller state machine: sequences decode, ring reads, byte puts and result loads.
// Depends on lzsw_pkg and lzsw_in_if.
module lzsw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	lzsw_in_if.sink           stream,
	input  lzsw_pkg::sts_t    sts,
	output lzsw_pkg::cmd_t    cmd,
	output lzsw_pkg::state_t  state
);

	lzsw_pkg::state_t state_q;
	lzsw_pkg::state_t state_d;

	assign state        = state_q;
	assign stream.ready = (state_q == lzsw_pkg::ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			lzsw_pkg::ST_IDLE: begin
				if (stream.valid) begin
					cmd.capture = 1'b1;
					state_d     = lzsw_pkg::ST_DECODE;
				end
			end
			lzsw_pkg::ST_DECODE: begin
				if (sts.flag_zero) begin
					if (!sts.byte_zero) begin
						cmd.set_flags = 1'b1;
						state_d       = lzsw_pkg::ST_IDLE;
					end else if (sts.out_free) begin
						cmd.end_stream = 1'b1;
						state_d        = lzsw_pkg::ST_IDLE;
					end
				end else if (sts.flag_lit) begin
					cmd.put_lit = 1'b1;
					state_d     = lzsw_pkg::ST_EMIT;
				end else if (!sts.awaiting) begin
					cmd.save_len = 1'b1;
					state_d      = lzsw_pkg::ST_IDLE;
				end else if (sts.len_zero) begin
					cmd.finish = 1'b1;
					state_d    = lzsw_pkg::ST_IDLE;
				end else begin
					cmd.start_copy = 1'b1;
					state_d        = lzsw_pkg::ST_RD;
				end
			end
			lzsw_pkg::ST_RD: begin
				cmd.ring_rd = 1'b1;
				state_d     = lzsw_pkg::ST_WR;
			end
			lzsw_pkg::ST_WR: begin
				cmd.put_copy = 1'b1;
				state_d      = (sts.lane_last || sts.last_put) ? lzsw_pkg::ST_EMIT
					: lzsw_pkg::ST_RD;
			end
			lzsw_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.remain_zero) begin
						cmd.finish = 1'b1;
						state_d    = lzsw_pkg::ST_IDLE;
					end else begin
						state_d = lzsw_pkg::ST_RD;
					end
				end
			end
			default: begin
				state_d = lzsw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sim/tb_lzss_window256_decoder.sv @@
// Self-checking testbench for the LZSS 256-byte window decoder.
// Depends on lzsw_pkg, lzsw_in_if, lzsw_out_if and lzss_window256_decoder.
// A built-in decoder predicts every result word, and random stalls are applied on both channels.
module tb_lzss_window256_decoder;

	typedef struct packed {
		logic [lzsw_pkg::OUT_LANES-1:0][7:0] lanes;
		logic [lzsw_pkg::CNT_W-1:0]          count;
		logic                                last;
		logic                                ends;
	} word_t;

	typedef struct {
		logic [7:0] data;
		bit         hold;   // wait for every pending result before sending this byte
	} stream_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lzsw_in_if  stream_bus ();
	lzsw_out_if result_bus ();

	lzss_window256_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_bus),
		.result (result_bus)
	);

	always #4 clk = ~clk;

	// Compressed bytes still to send, and the decoded words still to arrive.
	stream_item_t stream_q[$];
	word_t        decoded_words[$];

	// Decoder state mirrored on the testbench side.
	logic [7:0] flag_bits;
	logic       want_offset;
	logic [7:0] copy_len;
	logic [7:0] hist_ring [256];
	logic [7:0] hist_wp;

	// Packing of the bytes produced by the byte in flight.
	word_t      lane_acc;
	int         lane_fill;
	word_t      step_words[$];

	int errors = 0;
	int bytes_taken = 0;
	int words_seen = 0;
	bit results_settled;

	task automatic clear_history();
		flag_bits = '0;
		want_offset = 1'b0;
		copy_len = '0;
		hist_wp = '0;
		for (int i = 0; i < 256; i++)
			hist_ring[i] = '0;
	endtask

	task automatic flush_lanes();
		lane_acc.count = lzsw_pkg::CNT_W'(lane_fill);
		step_words.push_back(lane_acc);
		lane_acc = '0;
		lane_fill = 0;
	endtask

	// Write one decoded byte to the history and pack it into the next lane.
	task automatic emit_byte(input logic [7:0] b);
		hist_ring[hist_wp] = b;
		hist_wp++;
		lane_acc.lanes[lane_fill] = b;
		lane_fill++;
		if (lane_fill == lzsw_pkg::OUT_LANES)
			flush_lanes();
	endtask

	// Drop the consumed flag; only the sentinel left means a control byte is due.
	task automatic next_flag();
		flag_bits = flag_bits >> 1;
		if (flag_bits <= 8'd1)
			flag_bits = '0;
	endtask

	// Decode one compressed byte and queue the words it must produce.
	task automatic decode_byte(input logic [7:0] b);
		logic [7:0] src;
		word_t      w;
		step_words.delete();
		lane_acc = '0;
		lane_fill = 0;
		if (flag_bits == 8'd0) begin
			if (b == 8'd0) begin
				// Stream end: one empty word, then everything back to reset.
				w = '0;
				w.last = 1'b1;
				w.ends = 1'b1;
				decoded_words.push_back(w);
				clear_history();
			end else begin
				flag_bits = (b > 8'd1) ? b : 8'd0;
			end
			return;
		end
		if (flag_bits[0]) begin
			emit_byte(b);
			next_flag();
		end else if (!want_offset) begin
			copy_len = b;
			want_offset = 1'b1;
			return;
		end else begin
			// Copy byte by byte so an overlapping source repeats fresh output.
			src = hist_wp + b;
			for (int i = 0; i < int'(copy_len); i++) begin
				emit_byte(hist_ring[src]);
				src++;
			end
			want_offset = 1'b0;
			copy_len = '0;
			next_flag();
		end
		if (lane_fill != 0)
			flush_lanes();
		if (step_words.size() != 0) begin
			w = step_words.pop_back();
			w.last = 1'b1;
			step_words.push_back(w);
		end
		foreach (step_words[i])
			decoded_words.push_back(step_words[i]);
	endtask

	task automatic add_byte(input logic [7:0] data, input bit hold);
		stream_item_t it;
		it.data = data;
		it.hold = hold;
		stream_q.push_back(it);
	endtask

	// Sample at the falling edge so the pause check never races the monitor's pop.
	always @(negedge clk)
		results_settled <= (decoded_words.size() == 0);

	// Driver: hold the byte until taken, then wait a drawn gap before the next one.
	// Every third stretch of 40 bytes runs with no gaps at all.
	always @(posedge clk or negedge arst_n) begin : drive_stream
		bit take;
		int gap_left;
		if (!arst_n) begin
			stream_bus.valid <= 1'b0;
			stream_bus.in_byte <= '0;
			gap_left = 0;
		end else begin
			take = stream_bus.valid && stream_bus.ready;
			if (take) begin
				decode_byte(stream_bus.in_byte);
				void'(stream_q.pop_front());
				bytes_taken++;
				gap_left = ((bytes_taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 4);
			end
			// a held byte skips the edge of a take, so the settled flag sees its predictions
			if (stream_bus.valid && !take) begin
				// hold the current word
			end else if (gap_left > 0) begin
				gap_left--;
				stream_bus.valid <= 1'b0;
			end else if (stream_q.size() != 0
					&& !(stream_q[0].hold && (take || !results_settled))) begin
				stream_bus.valid <= 1'b1;
				stream_bus.in_byte <= stream_q[0].data;
			end else begin
				stream_bus.valid <= 1'b0;
			end
		end
	end

	// Monitor: check each taken word against the oldest prediction, then stall at random.
	always @(posedge clk or negedge arst_n) begin : watch_result
		word_t got;
		word_t want;
		int stall_left;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				got.lanes[0] = result_bus.out_byte0;
				got.lanes[1] = result_bus.out_byte1;
				got.lanes[2] = result_bus.out_byte2;
				got.lanes[3] = result_bus.out_byte3;
				got.count = result_bus.byte_count;
				got.last = result_bus.last_of_run;
				got.ends = result_bus.stream_end;
				words_seen++;
				if (decoded_words.size() == 0) begin
					if (errors < 10)
						$display("unexpected word: b=%02h %02h %02h %02h cnt=%0d last=%0b end=%0b",
							got.lanes[0], got.lanes[1], got.lanes[2], got.lanes[3],
							got.count, got.last, got.ends);
					errors++;
				end else begin
					want = decoded_words.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display("word %0d mismatch:", words_seen,
								" want b=%02h %02h %02h %02h cnt=%0d last=%0b end=%0b,",
								want.lanes[0], want.lanes[1], want.lanes[2],
								want.lanes[3], want.count, want.last, want.ends,
								" got b=%02h %02h %02h %02h cnt=%0d last=%0b end=%0b",
								got.lanes[0], got.lanes[1], got.lanes[2], got.lanes[3],
								got.count, got.last, got.ends);
						errors++;
					end
				end
				stall_left = ((words_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 4);
			end
			if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : run_test
		int n;
		int n_group;
		logic [7:0] ctl;
		stream_bus.valid = 1'b0;
		stream_bus.in_byte = '0;
		result_bus.ready = 1'b0;
		clear_history();

		// Directed: stream end from reset, empty control, all-literal group
		// with extreme values, zero-length copy, overlapping distance-1 copy,
		// a full-window copy that reaches before the first output, then end.
		add_byte(8'h00, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hA5, 1'b0);
		add_byte(8'h5A, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h7E, 1'b0);
		add_byte(8'h02, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h02, 1'b0);
		add_byte(8'h05, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h02, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b1);

		// Random: mostly well-formed groups, some stream ends, empty controls and noise.
		n_group = 0;
		while (stream_q.size() < 320) begin
			n = $urandom_range(0, 19);
			if (n == 0) begin
				add_byte(8'h00, n_group % 12 == 3);
			end else if (n == 1) begin
				add_byte(8'h01, n_group % 12 == 3);
			end else if (n == 2) begin
				repeat ($urandom_range(1, 6))
					add_byte(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				n = $urandom_range(1, 7);
				ctl = 8'(($urandom & ((1 << n) - 1)) | (1 << n));
				add_byte(ctl, n_group % 12 == 3);
				for (int k = 0; k < n; k++) begin
					if (ctl[k]) begin
						add_byte(8'($urandom_range(0, 255)), 1'b0);
					end else begin
						// keep most copies short; a few run near the full window
						if ($urandom_range(0, 24) == 0)
							add_byte(8'($urandom_range(128, 255)), 1'b0);
						else
							add_byte(8'($urandom_range(0, 12)), 1'b0);
						if ($urandom_range(0, 3) == 0)
							add_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
						else
							add_byte(8'($urandom_range(0, 255)), 1'b0);
					end
				end
			end
			n_group++;
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (stream_q.size() != 0 || decoded_words.size() != 0)
			@(posedge clk);
		// let a trailing byte with no word finish, and catch any stray word
		repeat (700) @(posedge clk);

		if (errors == 0) begin
			$display("[lzss_window256_decoder] OK");
		end else begin
			$display("[lzss_window256_decoder] ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#10000000;
		$display("[lzss_window256_decoder] ERROR");
		$finish;
	end

endmodule
